/* hdl/mcqc_pkg.sv */
// ----------------------------------------------------------------------------
// mcqc_pkg
// shared types and constants of the multi-channel quadrature counter unit
// ----------------------------------------------------------------------------
package mcqc_pkg;

  localparam int unsigned MAX_PAIRS = 5;
  localparam int unsigned OUT_W     = 32;
  localparam int unsigned TS_W      = 32;

  typedef enum logic [0:0] {
    ACT_SAMPLE = 1'b0,
    ACT_READ   = 1'b1
  } action_t;

  // phase codes: A*2 + B, recovery above the four live phases
  localparam logic [2:0] PHASE_RECOVERY = 3'd4;

  typedef struct packed {
    logic [0:0]      action;
    logic [7:0]      sample_high_byte;
    logic [7:0]      sample_low_byte;
    logic [TS_W-1:0] timestamp;
    logic [2:0]      pair_index;
  } in_req_t;

  typedef struct packed {
    logic [OUT_W-1:0] forward_steps;
    logic [OUT_W-1:0] backward_steps;
    logic [OUT_W-1:0] error_steps;
    logic [OUT_W-1:0] rises_a;
    logic [OUT_W-1:0] rises_b;
    logic [OUT_W-1:0] last_rise_a;
    logic [OUT_W-1:0] last_rise_b;
  } out_req_t;

  // classified request handed from front to back
  typedef struct packed {
    logic            is_read;
    logic [2:0]      pair_index;
    logic [9:0]      phases;     // pair p at bits 2p+1:2p
    logic [TS_W-1:0] timestamp;
  } cmd_t;

  // position along the forward cycle 00,10,11,01
  function automatic logic [1:0] cycle_pos(input logic [1:0] ph);
    logic [1:0] r;
    begin
      case (ph)
        2'd0:    r = 2'd0;
        2'd1:    r = 2'd3;
        2'd2:    r = 2'd1;
        default: r = 2'd2;
      endcase
      return r;
    end
  endfunction

endpackage

/* hdl/mcqc_front.sv */
// ----------------------------------------------------------------------------
// mcqc_front
// accepts requests, extracts pair phases, drops reads of absent pairs
// ----------------------------------------------------------------------------
module mcqc_front #(
  parameter int unsigned NUM_PAIRS = 5
) (
  input  logic             in_valid,
  output logic             in_stall,
  input  mcqc_pkg::in_req_t in_data,
  output logic             q_push,
  output mcqc_pkg::cmd_t   q_cmd,
  input  logic             q_full
);
  import mcqc_pkg::*;

  logic acc;

  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;

  always_comb begin
    q_cmd.is_read    = (in_data.action == ACT_READ);
    q_cmd.pair_index = in_data.pair_index;
    q_cmd.timestamp  = in_data.timestamp;
    q_cmd.phases     = {in_data.sample_low_byte[3:2], in_data.sample_high_byte[1:0],
                        in_data.sample_high_byte[3:2], in_data.sample_high_byte[5:4],
                        in_data.sample_high_byte[7:6]};
  end

  // a read of a pair that does not exist has no effect at all
  assign q_push = acc && !(q_cmd.is_read && ({29'd0, in_data.pair_index} >= NUM_PAIRS));

endmodule

/* hdl/mcqc_queue.sv */
// ----------------------------------------------------------------------------
// mcqc_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
module mcqc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  mcqc_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output mcqc_pkg::cmd_t head
);
  import mcqc_pkg::*;

  cmd_t       mem_r [2];
  logic       wr_r, wr_nxt, rd_r, rd_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign head      = mem_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r ^ push;
    rd_nxt  = rd_r ^ pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

endmodule

/* hdl/mcqc_back.sv */
// ----------------------------------------------------------------------------
// mcqc_back
// per-pair quadrature machines, counters and read-out register
// ----------------------------------------------------------------------------
module mcqc_back #(
  parameter int unsigned NUM_PAIRS   = 5,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  mcqc_pkg::cmd_t    q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output mcqc_pkg::out_req_t out_data
);
  import mcqc_pkg::*;

  localparam int unsigned CW = COUNT_WIDTH;

  logic [2:0]      phase_r  [NUM_PAIRS];
  logic [2:0]      pre_r    [NUM_PAIRS];
  logic [CW-1:0]   fwd_r    [NUM_PAIRS];
  logic [CW-1:0]   bwd_r    [NUM_PAIRS];
  logic [CW-1:0]   err_r    [NUM_PAIRS];
  logic [CW-1:0]   rcnt_r   [2*NUM_PAIRS];
  logic [TS_W-1:0] rtime_r  [2*NUM_PAIRS];

  logic     ov_r, ov_nxt;
  out_req_t od_r;
  logic     take, sample;

  // a read may only go when the output register is free or draining
  assign q_pop   = q_valid && (!q_cmd.is_read || !ov_r || !out_stall);
  assign take    = q_pop && q_cmd.is_read;
  assign sample  = q_pop && !q_cmd.is_read;
  assign ov_nxt  = take || (ov_r && out_stall);
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
  end

  function automatic logic [OUT_W-1:0] lo32(input logic [CW-1:0] v);
    logic [CW+OUT_W-1:0] w;
    begin
      w = {{OUT_W{1'b0}}, v};
      return w[OUT_W-1:0];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (take) begin
      od_r.forward_steps  <= lo32(fwd_r[q_cmd.pair_index]);
      od_r.backward_steps <= lo32(bwd_r[q_cmd.pair_index]);
      od_r.error_steps    <= lo32(err_r[q_cmd.pair_index]);
      od_r.rises_a        <= lo32(rcnt_r[{q_cmd.pair_index, 1'b0}]);
      od_r.rises_b        <= lo32(rcnt_r[{q_cmd.pair_index, 1'b1}]);
      od_r.last_rise_a    <= rtime_r[{q_cmd.pair_index, 1'b0}];
      od_r.last_rise_b    <= rtime_r[{q_cmd.pair_index, 1'b1}];
    end
  end

  for (genvar p = 0; p < NUM_PAIRS; p++) begin : g_pair
    logic [1:0] now, ref_ph, up, d;
    logic       rec;

    assign now    = q_cmd.phases[2*p +: 2];
    assign rec    = phase_r[p][2];
    assign ref_ph = rec ? (pre_r[p][2] ? 2'd0 : pre_r[p][1:0]) : phase_r[p][1:0];
    assign up     = (rec || now != phase_r[p][1:0]) ? (now & ~ref_ph) : 2'b00;
    assign d      = cycle_pos(now) - cycle_pos(phase_r[p][1:0]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        phase_r[p]      <= PHASE_RECOVERY;
        pre_r[p]        <= PHASE_RECOVERY;
        fwd_r[p]        <= '0;
        bwd_r[p]        <= '0;
        err_r[p]        <= '0;
        rcnt_r[2*p]     <= '0;
        rcnt_r[2*p+1]   <= '0;
        rtime_r[2*p]    <= '0;
        rtime_r[2*p+1]  <= '0;
      end else if (sample) begin
        if (up[1]) begin
          rcnt_r[2*p]  <= rcnt_r[2*p] + 1'b1;
          rtime_r[2*p] <= q_cmd.timestamp;
        end
        if (up[0]) begin
          rcnt_r[2*p+1]  <= rcnt_r[2*p+1] + 1'b1;
          rtime_r[2*p+1] <= q_cmd.timestamp;
        end
        if (rec) begin
          phase_r[p] <= {1'b0, now};
        end else if (d == 2'd1) begin
          fwd_r[p]   <= fwd_r[p] + 1'b1;
          phase_r[p] <= {1'b0, now};
        end else if (d == 2'd3) begin
          bwd_r[p]   <= bwd_r[p] + 1'b1;
          phase_r[p] <= {1'b0, now};
        end else if (d == 2'd2) begin
          err_r[p]   <= err_r[p] + 1'b1;
          pre_r[p]   <= phase_r[p];
          phase_r[p] <= PHASE_RECOVERY;
        end
      end
    end
  end

endmodule

/* hdl/multi_channel_quadrature_counter_unit.sv */
// ----------------------------------------------------------------------------
// multi_channel_quadrature_counter_unit
// x4 quadrature decoder for up to five A/B pairs with rising-edge logging
// ----------------------------------------------------------------------------
// one request per clock is taken in and carried out; a sample request
// updates every pair at the edge where it leaves the two-entry queue,
// and a read request's counters appear on the result port from that same
// edge, after the request has first been written into the queue. requests
// move through the front stage, the queue and the per-pair back end, so
// input and output stall independently; the only limit on rate is a
// stalled output register holding back further read requests, which
// fills the queue and then stalls the input.
module multi_channel_quadrature_counter_unit #(
  parameter int unsigned NUM_PAIRS   = 5,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mcqc_pkg::in_req_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mcqc_pkg::out_req_t out_data
);
  import mcqc_pkg::*;

  logic q_push, q_full, q_pop, q_ne;
  cmd_t push_cmd, head_cmd;

  // front: decode and classify requests
  mcqc_front #(.NUM_PAIRS(NUM_PAIRS)) u_front (
    .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .q_push(q_push), .q_cmd(push_cmd), .q_full(q_full)
  );

  // decoupling queue
  mcqc_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_cmd(push_cmd), .full(q_full),
    .pop(q_pop), .not_empty(q_ne), .head(head_cmd)
  );

  // back: quadrature machines and read-out
  mcqc_back #(.NUM_PAIRS(NUM_PAIRS), .COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_ne), .q_cmd(head_cmd), .q_pop(q_pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // queue never pops when empty
  a_pop_ne: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_ne)
    else $error("pop from empty queue");
  // queue never pushed when full
  a_push_nf: assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
    else $error("push to full queue");
  // a read leaving the queue always lands in the output register
  a_read_out: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && head_cmd.is_read) |=> out_valid)
    else $error("read request lost");

endmodule
